/* hdl/hds_pkg.sv */
// Shared widths and constants for the 2x2 half downsampler.
package hds_pkg;

	localparam int unsigned PIXEL_W            = 8;
	localparam int unsigned HALF_WIDTH_W       = 11;
	localparam int unsigned MAX_HALF_WIDTH_DEF = 1024;
	localparam int unsigned HALF_WIDTH_RESET   = 1024;

	typedef logic [PIXEL_W-1:0]      pixel_t;
	typedef logic [HALF_WIDTH_W-1:0] half_width_t;

endpackage

/* hdl/half_downsample_2x2_core.sv */
// Top level of the 2x2 box-filter half downsampler with its line store.
//
//  channel  direction  signals
//  -------  ---------  ------------------------------------------------
//  input    in         in_valid, in_ready, pixel, frame_start
//  output   out        out_valid, out_ready, out_pixel, row_end
//  config   in         cfg_we, cfg_data (half width, no wait)
//
// One source pixel is taken per cycle unless a full read stage stalls; the
// line store is touched at most once per pixel pair, so one port suffices.
// Odd-row right pixel results go via the read stage to the output register.
// Reset clears the position and the pipeline; the line store is not cleared.
// A stalled output holds one result in the output register and one in the
// read stage before the input side stops taking pixels.
module half_downsample_2x2_core #(
	parameter int unsigned MAX_HALF_WIDTH = hds_pkg::MAX_HALF_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hds_pkg::pixel_t     pixel,
	input  logic                frame_start,
	output logic                out_valid,
	input  logic                out_ready,
	output hds_pkg::pixel_t     out_pixel,
	output logic                row_end,
	input  logic                cfg_we,
	input  hds_pkg::half_width_t cfg_data
);
	import hds_pkg::*;

	localparam int unsigned HWW = $clog2(MAX_HALF_WIDTH + 1);
	localparam int unsigned CW  = $clog2(2 * MAX_HALF_WIDTH);
	localparam int unsigned IW  = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
	localparam int unsigned HW_RST = (HALF_WIDTH_RESET > MAX_HALF_WIDTH) ?
		MAX_HALF_WIDTH : HALF_WIDTH_RESET;

	logic [HWW-1:0] hw_eff_q;
	logic [HWW:0]   src_w;
	logic [CW-1:0]  col_q;
	logic           odd_q;
	pixel_t         left_q;

	logic           in_fire;
	logic [CW-1:0]  col0;
	logic           odd0;
	logic [CW-1:0]  col1;
	logic           odd1;
	logic [CW:0]    col2;
	logic [IW-1:0]  idx;
	logic [PIXEL_W:0] pair_sum;
	pixel_t         h;
	logic           is_right;
	logic           mem_we;
	logic           mem_re;

	pixel_t         line_mem [MAX_HALF_WIDTH];
	pixel_t         mem_rd_s1;
	logic           valid_s1;
	pixel_t         h_half_s1;
	logic           last_s1;
	logic           adv_s1;

	logic           out_valid_q;
	pixel_t         out_pixel_q;
	logic           row_end_q;

	assign src_w = {hw_eff_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_eff_q <= HWW'(HW_RST);
		end else if (cfg_we) begin
			if (cfg_data == '0) begin
				hw_eff_q <= HWW'(1);
			end else if (32'(cfg_data) > 32'(MAX_HALF_WIDTH)) begin
				hw_eff_q <= HWW'(MAX_HALF_WIDTH);
			end else begin
				hw_eff_q <= HWW'(cfg_data);
			end
		end
	end

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		col0 = frame_start ? '0 : col_q;
		odd0 = frame_start ? 1'b0 : odd_q;
		if (32'(col0) >= 32'(src_w)) begin
			col1 = '0;
			odd1 = !odd0;
		end else begin
			col1 = col0;
			odd1 = odd0;
		end
		col2     = {1'b0, col1} + (CW+1)'(1);
		is_right = col1[0];
		idx      = IW'(col1 >> 1);
		pair_sum = {1'b0, left_q} + {1'b0, pixel};
		h        = pair_sum[PIXEL_W:1];
		mem_we   = in_fire && is_right && !odd1;
		mem_re   = in_fire && is_right && odd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			odd_q  <= 1'b0;
			left_q <= '0;
		end else if (in_fire) begin
			if (32'(col2) >= 32'(src_w)) begin
				col_q <= '0;
				odd_q <= !odd1;
			end else begin
				col_q <= CW'(col2);
				odd_q <= odd1;
			end
			if (!is_right) begin
				left_q <= pixel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[idx] <= h;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			mem_rd_s1 <= line_mem[idx];
			h_half_s1 <= h >> 1;
			last_s1   <= (32'(idx) == 32'(hw_eff_q) - 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (mem_re) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_pixel_q <= (mem_rd_s1 >> 1) + h_half_s1;
			row_end_q   <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign row_end   = row_end_q;

`ifndef SYNTHESIS
	a_read_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> valid_s1)
		else $error("read stage not loaded after a line store read");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(h_half_s1) && $stable(mem_rd_s1))
		else $error("stalled read stage lost its contents");

	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid)
		else $error("advanced result not presented on the output");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input taken while both stages are full and stalled");
`endif

endmodule
